[rtl/u8u16_pkg.sv]
// shared types and constants for the utf-8 to utf-16be transcoder
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CP_W = 21;

  localparam logic [7:0]      ASCII_MAX  = 8'h7F;
  localparam logic [CP_W-1:0] BMP_LO_MAX = 21'h00D7FF;
  localparam logic [CP_W-1:0] BMP_HI_MIN = 21'h00E000;
  localparam logic [CP_W-1:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [CP_W-1:0] SUPP_MIN   = 21'h010000;
  localparam logic [CP_W-1:0] SUPP_MAX   = 21'h10FFFF;
  localparam logic [15:0]     HI_SURR    = 16'hD800;
  localparam logic [15:0]     LO_SURR    = 16'hDC00;
  localparam logic [9:0]      SURR_MASK  = 10'h3FF;

  // one queued code point, already split into utf-16 words
  typedef struct packed {
    logic        quad;  // surrogate pair, four bytes
    logic [15:0] w0;
    logic [15:0] w1;
  } entry_t;

endpackage

[rtl/u8u16_if.sv]
// byte channels of the transcoder
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[rtl/u8u16_front.sv]
// front end: utf-8 decode and utf-16 word formation
module u8u16_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  input  logic              full,
  output logic              push,
  output u8u16_pkg::entry_t push_entry
);
  import u8u16_pkg::*;

  logic [1:0]      pending_r, pending_nxt;
  logic [CP_W-1:0] partial_r, partial_nxt;
  logic            accept;
  logic            complete;
  logic [CP_W-1:0] cp;
  logic            is_bmp, is_supp;
  logic [CP_W-1:0] off_full;
  logic [19:0]     off;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pending_nxt = pending_r;
    partial_nxt = partial_r;
    complete    = 1'b0;
    cp          = {partial_r[CP_W-7:0], in_byte[5:0]};
    if (pending_r != 2'd0) begin
      partial_nxt = cp;
      pending_nxt = pending_r - 2'd1;
      complete    = (pending_r == 2'd1);
    end else begin
      cp = {{(CP_W-8){1'b0}}, in_byte};
      case (in_byte) inside
        [8'h00:ASCII_MAX]: begin
          partial_nxt = cp;
          complete    = 1'b1;
        end
        [8'hC0:8'hDF]: begin
          partial_nxt = {{(CP_W-5){1'b0}}, in_byte[4:0]};
          pending_nxt = 2'd1;
        end
        [8'hE0:8'hEF]: begin
          partial_nxt = {{(CP_W-4){1'b0}}, in_byte[3:0]};
          pending_nxt = 2'd2;
        end
        [8'hF0:8'hFF]: begin
          partial_nxt = {{(CP_W-3){1'b0}}, in_byte[2:0]};
          pending_nxt = 2'd3;
        end
        default: begin
          // stray continuation in lead position: no effect
        end
      endcase
    end
  end

  assign is_bmp   = (cp <= BMP_LO_MAX) || (cp >= BMP_HI_MIN && cp <= BMP_MAX);
  assign is_supp  = (cp >= SUPP_MIN) && (cp <= SUPP_MAX);
  assign off_full = cp - SUPP_MIN;
  assign off      = off_full[19:0];

  always_comb begin
    push_entry.quad = is_supp;
    if (is_supp) begin
      push_entry.w0 = HI_SURR | {6'd0, off[19:10]};
      push_entry.w1 = LO_SURR | {6'd0, off[9:0] & SURR_MASK};
    end else begin
      push_entry.w0 = cp[15:0];
      push_entry.w1 = cp[15:0];
    end
  end

  assign push = accept && complete && (is_bmp || is_supp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      partial_r <= '0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_push_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r > 2'd1) |-> !push) else $error("push before sequence end");
  a_push_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_valid) else $error("push without input beat");

endmodule

[rtl/u8u16_queue.sv]
// small fifo of decoded code points between front and back
module u8u16_queue #(
  parameter int QDEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8u16_pkg::entry_t push_entry,
  input  logic              pop,
  output u8u16_pkg::entry_t head,
  output logic              empty,
  output logic              full
);
  import u8u16_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  entry_t        mem [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(QDEPTH));
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH)) else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wr_ptr_r == rd_ptr_r)) else $error("pointers out of step");

endmodule

[rtl/u8u16_back.sv]
// back end: serializes queued utf-16 words into output bytes
module u8u16_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8u16_pkg::entry_t head,
  input  logic              empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import u8u16_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic       final_beat;
  logic [7:0] sel_byte;

  assign load       = (!out_valid_r || out_ready) && !empty;
  assign final_beat = head.quad ? (idx_r == 2'd3) : (idx_r == 2'd1);
  assign pop        = load && final_beat;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.w0[15:8];
      2'd1:    sel_byte = head.w0[7:0];
      2'd2:    sel_byte = head.w1[15:8];
      default: sel_byte = head.w1[7:0];
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    if (load) begin
      idx_nxt       = final_beat ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = sel_byte;
      last_nxt      = final_beat;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = last_r;

  // a partly sent entry stays at the queue head
  a_idx_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !empty) else $error("byte index without entry");
  a_idx_quad: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == 2'd2 || idx_r == 2'd3) |-> head.quad) else $error("pair index on bmp entry");
  a_pop_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid && out_last)) else $error("entry retired without last beat");

endmodule

[rtl/utf8_to_utf16be_transcoder_unit.sv]
// top level of the utf-8 to utf-16 big-endian transcoder
// Takes one UTF-8 byte per input beat and sends UTF-16BE bytes, high byte first, with last
// set on the final byte caused by an input byte. Bytes that complete no code point, and code
// points that UTF-16 cannot carry, cause no output. The decoder front end accepts one byte a
// cycle while its code point queue (QDEPTH entries) has room; the back end sends one output
// byte a cycle, while the output is ready, from a registered output stage. Sustained rate is
// bounded by that output port: an ASCII byte yields two output bytes and a four-byte sequence
// yields four. The first output byte of a code point passes through the queue entry and then
// the output register.
module utf8_to_utf16be_transcoder_unit #(
  parameter int QDEPTH = u8u16_pkg::QUEUE_DEPTH  // 2 or more
) (
  input logic          clk,
  input logic          rst_n,
  u8u16_in_if.sink     in_ch,
  u8u16_out_if.source  out_ch
);
  import u8u16_pkg::*;

  entry_t push_entry;
  entry_t head;
  logic   push, pop, empty, full;

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_byte    (in_ch.in_byte),
    .in_ready   (in_ch.ready),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  u8u16_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
  );

endmodule

[sim/utf8_to_utf16be_transcoder_unit_tb.sv]
// testbench for the utf-8 to utf-16be transcoder: directed table, then random byte stream
`timescale 1ns / 100ps

module utf8_to_utf16be_transcoder_unit_tb;
  import u8u16_pkg::*;

  localparam int N_DIRECTED   = 26;
  localparam int CALM_TAIL    = 30;
  localparam int RANDOM_ITEMS = 134;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  // utf-8 tag bits above the payload
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [3:0] LEAD4_TAG = 4'b1111;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  // one row of the directed table; bytes holds the first output byte in [31:24]
  typedef struct packed {
    logic [7:0]  din;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] bytes;
  } row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } utf16_beat_t;

  logic clk;
  logic rst_n;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16be_transcoder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf16_beat_t expected_q [$];
  logic [7:0]  utf8_q [$];
  utf16_beat_t seen_want;

  // decoder state mirrored from the block
  logic [1:0]  cont_left;
  logic [20:0] cp_acc;

  bit          calm;
  bit          quiet;
  int          ready_hold;
  int          idle_cycles;
  int unsigned failures;
  int unsigned bytes_in;
  int unsigned bytes_out;
  int unsigned pairs_out;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic row_t directed_row(input int idx);
    case (idx)
      0:  return {8'h00, 1'b1, 3'd2, 32'h0000_0000};
      1:  return {8'h7F, 1'b1, 3'd2, 32'h007F_0000};
      2:  return {8'h80, 1'b1, 3'd0, 32'h0};  // stray continuation
      3:  return {8'hBF, 1'b1, 3'd0, 32'h0};
      4:  return {8'hC0, 1'b1, 3'd0, 32'h0};
      5:  return {8'h80, 1'b1, 3'd2, 32'h0000_0000};  // overlong zero
      6:  return {8'hD0, 1'b1, 3'd0, 32'h0};  // upper two-byte lead
      7:  return {8'h41, 1'b0, 3'd0, 32'h0};  // continuation with wrong tag bits
      8:  return {8'hED, 1'b1, 3'd0, 32'h0};
      9:  return {8'hA0, 1'b1, 3'd0, 32'h0};
      10: return {8'h80, 1'b1, 3'd0, 32'h0};  // surrogate code point, dropped
      11: return {8'hEF, 1'b1, 3'd0, 32'h0};
      12: return {8'hBF, 1'b1, 3'd0, 32'h0};
      13: return {8'hBF, 1'b1, 3'd2, 32'hFFFF_0000};
      14: return {8'hF0, 1'b1, 3'd0, 32'h0};
      15: return {8'h90, 1'b1, 3'd0, 32'h0};
      16: return {8'h80, 1'b1, 3'd0, 32'h0};
      17: return {8'h80, 1'b1, 3'd4, 32'hD800_DC00};
      18: return {8'hF4, 1'b1, 3'd0, 32'h0};
      19: return {8'h8F, 1'b1, 3'd0, 32'h0};
      20: return {8'hBF, 1'b1, 3'd0, 32'h0};
      21: return {8'hBF, 1'b1, 3'd4, 32'hDBFF_DFFF};
      22: return {8'hFF, 1'b1, 3'd0, 32'h0};
      23: return {8'hFF, 1'b1, 3'd0, 32'h0};
      24: return {8'hFF, 1'b1, 3'd0, 32'h0};
      default: return {8'hFF, 1'b1, 3'd0, 32'h0};  // beyond 0x10ffff, dropped
    endcase
  endfunction

  // steps the mirrored decoder by one byte, returns the number of utf-16 bytes
  function automatic int utf16_of_utf8(input logic [7:0] b, output logic [31:0] obytes);
    bit          done;
    logic [20:0] offs;
    logic [15:0] hi_w;
    logic [15:0] lo_w;
    done   = 1'b0;
    obytes = '0;
    if (cont_left != 2'd0) begin
      cp_acc    = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      done      = (cont_left == 2'd0);
    end else if (b <= ASCII_MAX) begin
      cp_acc = {13'd0, b};
      done   = 1'b1;
    end else if (b[7:5] == LEAD2_TAG) begin
      cp_acc    = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b[7:4] == LEAD3_TAG) begin
      cp_acc    = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (b[7:4] == LEAD4_TAG) begin
      cp_acc    = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end
    if (!done)
      return 0;
    if (cp_acc <= BMP_LO_MAX || (cp_acc >= BMP_HI_MIN && cp_acc <= BMP_MAX)) begin
      obytes = {cp_acc[15:0], 16'h0000};
      return 2;
    end
    if (cp_acc >= SUPP_MIN && cp_acc <= SUPP_MAX) begin
      offs   = cp_acc - SUPP_MIN;
      hi_w   = HI_SURR + {6'd0, offs[19:10]};
      lo_w   = LO_SURR + {6'd0, offs[9:0] & SURR_MASK};
      obytes = {hi_w, lo_w};
      return 4;
    end
    return 0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input int tn,
                           input logic [31:0] tbytes);
    int          gap;
    int          n;
    logic [31:0] pb;
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    n = utf16_of_utf8(b, pb);
    if (typed) begin
      n  = tn;
      pb = tbytes;
    end
    for (int k = 0; k < n; k++)
      expected_q.push_back({pb[31-8*k -: 8], (k == n - 1)});
    if (n == 4)
      pairs_out++;
    bytes_in++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // output ready with random stall bursts, and quiet stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 49) == 0)
      quiet <= !quiet;
    if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= ready_hold - 1;
    end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_out++;
      if (expected_q.size() == 0) begin
        $error("out_byte: nothing expected, got %h (last %b)", out_ch.out_byte, out_ch.last);
        failures++;
      end else begin
        seen_want = expected_q.pop_front();
        if (out_ch.out_byte !== seen_want.b) begin
          $error("out_byte: expected %h, got %h", seen_want.b, out_ch.out_byte);
          failures++;
        end
        if (out_ch.last !== seen_want.last) begin
          $error("last: expected %b, got %b", seen_want.last, out_ch.last);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t        row;
    logic [20:0] cp;
    logic [7:0]  lead;
    logic [5:0]  six;
    logic [1:0]  tag;
    int          len;
    int          pick;
    int          n_random;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    cont_left     = 2'd0;
    cp_acc        = '0;
    calm          = 1'b0;
    quiet         = 1'b0;
    ready_hold    = 0;
    idle_cycles   = 0;
    failures      = 0;
    bytes_in      = 0;
    bytes_out     = 0;
    pairs_out     = 0;
    n_random      = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_row(i);
      send_byte(row.din, row.typed, int'(row.n), row.bytes);
    end
    drain_results();

    // mostly well-formed sequences with random payload, some noise and cut sequences
    while (n_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      len  = 0;
      if (pick < 20) begin
        cp  = 21'($urandom_range(0, 'h7F));
        len = 1;
      end else if (pick < 35) begin
        cp  = 21'($urandom_range(0, 'h7FF));
        len = 2;
      end else if (pick < 55) begin
        len = 3;
        case ($urandom_range(0, 3))
          0: cp = 21'($urandom_range('hD800, 'hDFFF));
          1: begin
            case ($urandom_range(0, 3))
              0: cp = 21'h00D7FF;
              1: cp = 21'h00E000;
              2: cp = 21'h00FFFF;
              default: cp = 21'h000800;
            endcase
          end
          default: cp = 21'($urandom_range(0, 'hFFFF));
        endcase
      end else if (pick < 80) begin
        len = 4;
        if ($urandom_range(0, 3) == 0)
          cp = 21'($urandom_range(0, 'h1FFFFF));
        else
          cp = 21'($urandom_range('h10000, 'h10FFFF));
      end else if (pick < 88) begin
        utf8_q.push_back(8'($urandom_range('h80, 'hBF)));
        n_random++;
      end else if (pick < 95) begin
        utf8_q.push_back(8'($urandom_range('hC0, 'hFF)));
        n_random++;
      end else begin
        utf8_q.push_back(8'($urandom_range(0, 'hFF)));
        n_random++;
      end

      if (len == 1) begin
        utf8_q.push_back(cp[7:0]);
        n_random++;
      end else if (len > 1) begin
        case (len)
          2: lead = {LEAD2_TAG, cp[10:6]};
          3: lead = {LEAD3_TAG, cp[15:12]};
          default: lead = {LEAD4_TAG, 1'b0, cp[20:18]};
        endcase
        utf8_q.push_back(lead);
        for (int k = len - 2; k >= 0; k--) begin
          six = 6'(cp >> (6 * k));
          tag = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : CONT_TAG;
          utf8_q.push_back({tag, six});
        end
        n_random += len;
      end
    end
    // sequence left open at the end of the stream
    utf8_q.push_back({LEAD4_TAG, 4'h0});

    for (int i = 0; i < utf8_q.size(); i++) begin
      if (i == utf8_q.size() / 2)
        drain_results();
      if (i >= utf8_q.size() - CALM_TAIL)
        calm = 1'b1;
      send_byte(utf8_q[i], 1'b0, 0, 32'h0);
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d utf-8 bytes in (%0d from the directed table) and %0d utf-16 bytes out",
             bytes_in, N_DIRECTED, bytes_out);
    $display("  including %0d surrogate pairs, strays, unchecked continuations and dropped points",
             pairs_out);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16be_transcoder_unit.sv
sim/utf8_to_utf16be_transcoder_unit_tb.sv
